[rtl/pts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  // Fixed field widths of the transfer payloads.
  localparam int DATA_WIDTH   = 16;
  // Width of a sine table entry; 2^(SAMPLE_WIDTH-1)-1 stands for 1.0.
  localparam int SAMPLE_WIDTH = 16;
  // Angle bits in use; 2^ANGLE_WIDTH is one full turn.
  localparam int ANGLE_WIDTH  = 16;

  typedef enum logic {
    OP_FWD = 1'b0,
    OP_INV = 1'b1
  } op_t;

  typedef struct packed {
    op_t                           op;
    logic signed [DATA_WIDTH-1:0]  x_in;
    logic signed [DATA_WIDTH-1:0]  y_in;
    logic        [DATA_WIDTH-1:0]  angle;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  x_out;
    logic signed [DATA_WIDTH-1:0]  y_out;
    logic                          clipped;
  } out_t;

endpackage

`default_nettype wire

[rtl/park_transform_lut_sincos.sv]
// An input transfer travels the pipeline stages to its result on the output register.
// Throughput: one item per cycle; the whole pipeline moves together and holds on a stall.
// Sine and cosine come from a constant dual-read table, so no fill or clear follows reset.
// Reset (rst_n low, synchronous) empties the pipeline: all valid bits and out_valid clear.
`timescale 1ns / 1ps
`default_nettype none

module park_transform_lut_sincos import pts_pkg::*; #(
  parameter int TABLE_SIZE = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_ready,
  input  wire in_t  in_data,
  output      logic out_valid,
  input  wire logic out_ready,
  output      out_t out_data
);

  // Pipeline map:
  //   stage 1  angle times table size, split into index and fraction
  //   stage 2  registered table read of {e[i+1], e[i]} for sine and cosine
  //   stage 3  linear interpolation (one multiply each)
  //   stage 4  the four products of the rotation
  //   stage 5  sum, round, saturate into the output register
  // A single advance signal moves every stage; it is high whenever the output
  // register is empty or its transfer completes, so a stall freezes everything
  // in place and nothing is dropped or repeated.

  localparam int PROD_W = DATA_WIDTH + SAMPLE_WIDTH;
  localparam int ACC_W  = PROD_W + 1;
  localparam int RND_W  = PROD_W + 2;
  localparam int LAT_SC = 3;

  logic adv;

  logic [LAT_SC-1:0] vld_r;
  logic signed [DATA_WIDTH-1:0] x_pipe_r [LAT_SC];
  logic signed [DATA_WIDTH-1:0] y_pipe_r [LAT_SC];
  op_t                          op_pipe_r [LAT_SC];

  logic signed [SAMPLE_WIDTH-1:0] sin_val;
  logic signed [SAMPLE_WIDTH-1:0] cos_val;

  logic                     vld4_r;
  op_t                      op4_r;
  logic signed [PROD_W-1:0] xc_r;
  logic signed [PROD_W-1:0] ys_r;
  logic signed [PROD_W-1:0] yc_r;
  logic signed [PROD_W-1:0] xs_r;

  logic                    out_valid_r;
  out_t                    out_r;
  out_t                    out_nxt;
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic [DATA_WIDTH:0]     sat_x;
  logic [DATA_WIDTH:0]     sat_y;

  // Round half up at bit SAMPLE_WIDTH-1, then clamp to 16 bits.
  // Returns {clip, value}.
  function automatic logic [DATA_WIDTH:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [RND_W-1:0] rnd;
    logic signed [RND_W-1:0] sh;
    logic [DATA_WIDTH:0]     res;
    rnd = RND_W'(acc) + (RND_W'(1) <<< (SAMPLE_WIDTH - 2));
    sh  = rnd >>> (SAMPLE_WIDTH - 1);
    if (sh > RND_W'(32767)) begin
      res = {1'b1, 16'sh7FFF};
    end else if (sh < RND_W'(-32768)) begin
      res = {1'b1, 16'sh8000};
    end else begin
      res = {1'b0, sh[DATA_WIDTH-1:0]};
    end
    return res;
  endfunction

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Stages 1 to 3 for the angle live in the sine/cosine unit; the operands and
  // the operation travel alongside in a matching delay line.
  pts_sincos #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_sincos (
    .clk    (clk),
    .adv    (adv),
    .angle  (in_data.angle[ANGLE_WIDTH-1:0]),
    .sin_val(sin_val),
    .cos_val(cos_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      vld4_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT_SC-2:0], in_valid};
      vld4_r      <= vld_r[LAT_SC-1];
      out_valid_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_pipe_r[0]  <= in_data.x_in;
      y_pipe_r[0]  <= in_data.y_in;
      op_pipe_r[0] <= in_data.op;
      for (int i = 1; i < LAT_SC; i++) begin
        x_pipe_r[i]  <= x_pipe_r[i-1];
        y_pipe_r[i]  <= y_pipe_r[i-1];
        op_pipe_r[i] <= op_pipe_r[i-1];
      end
      op4_r <= op_pipe_r[LAT_SC-1];
      xc_r  <= PROD_W'(x_pipe_r[LAT_SC-1]) * PROD_W'(cos_val);
      ys_r  <= PROD_W'(y_pipe_r[LAT_SC-1]) * PROD_W'(sin_val);
      yc_r  <= PROD_W'(y_pipe_r[LAT_SC-1]) * PROD_W'(cos_val);
      xs_r  <= PROD_W'(x_pipe_r[LAT_SC-1]) * PROD_W'(sin_val);
      out_r <= out_nxt;
    end
  end

  // Forward Park:  d = x*cos + y*sin,  q = y*cos - x*sin.
  // Inverse Park:  alpha = x*cos - y*sin,  beta = x*sin + y*cos.
  always_comb begin
    case (op4_r)
      OP_FWD: begin
        acc_x = ACC_W'(xc_r) + ACC_W'(ys_r);
        acc_y = ACC_W'(yc_r) - ACC_W'(xs_r);
      end
      OP_INV: begin
        acc_x = ACC_W'(xc_r) - ACC_W'(ys_r);
        acc_y = ACC_W'(xs_r) + ACC_W'(yc_r);
      end
      default: begin
        acc_x = '0;
        acc_y = '0;
      end
    endcase
    sat_x           = round_sat(acc_x);
    sat_y           = round_sat(acc_y);
    out_nxt.x_out   = sat_x[DATA_WIDTH-1:0];
    out_nxt.y_out   = sat_y[DATA_WIDTH-1:0];
    out_nxt.clipped = sat_x[DATA_WIDTH] || sat_y[DATA_WIDTH];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // An accepted item that meets no stall reaches the output register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 adv ##1 adv ##1 adv ##1 adv |=> out_valid)
    else $error("accepted item did not reach the output in five cycles");

  // A stall freezes the valid bits of every stage ahead of the output register.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(vld4_r))
    else $error("pipeline valid bits moved during a stall");

  // The clip flag implies that at least one result sits at a rail.
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.clipped
      || out_data.x_out == 16'sh7FFF || out_data.x_out == 16'sh8000
      || out_data.y_out == 16'sh7FFF || out_data.y_out == 16'sh8000)
    else $error("clipped set without a saturated result");

  // Input is taken exactly when the output side can move.
  a_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while the output register is stalled");

endmodule

`default_nettype wire

[rtl/pts_sincos.sv]
`timescale 1ns / 1ps
`default_nettype none

module pts_sincos import pts_pkg::*; #(
  parameter int TABLE_SIZE = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           adv,
  input  wire logic        [ANGLE_WIDTH-1:0]  angle,
  output      logic signed [SAMPLE_WIDTH-1:0] sin_val,
  output      logic signed [SAMPLE_WIDTH-1:0] cos_val
);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int P_W    = ANGLE_WIDTH + IDX_W;
  localparam int WORD_W = 2 * SAMPLE_WIDTH;
  localparam int D_W    = SAMPLE_WIDTH + 1;
  localparam int T_W    = SAMPLE_WIDTH + ANGLE_WIDTH + 2;
  localparam int V_W    = SAMPLE_WIDTH + 2;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Each word holds an entry and its wrapped successor: {e[i+1], e[i]}.
  typedef logic [WORD_W-1:0] rom_word_t;
  typedef rom_word_t rom_arr_t [TABLE_SIZE];

  // Sine of a Q30 angle in [0, pi/2] by a truncated nine-term series.
  function automatic longint unsigned sin_q30(input longint unsigned theta);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (theta * theta) >> 30;
    term = theta;
    sum  = longint'(theta);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    return longint'(sum);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sine_entry(input int i);
    longint unsigned four;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned theta;
    longint unsigned mag;
    longint unsigned scale;
    logic signed [SAMPLE_WIDTH-1:0] m;
    scale = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;
    four  = 64'd4 * 64'(i);
    quad  = four / 64'(TABLE_SIZE);
    r     = four - quad * 64'(TABLE_SIZE);
    if (quad[0]) begin
      r = 64'(TABLE_SIZE) - r;
    end
    theta = (r * HALF_PI_Q30 + 64'(TABLE_SIZE / 2)) / 64'(TABLE_SIZE);
    mag   = (sin_q30(theta) * scale + (64'd1 << 29)) >> 30;
    m     = SAMPLE_WIDTH'(mag);
    return (quad >= 64'd2) ? -m : m;
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t rom;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      rom[i] = {sine_entry((i + 1 == TABLE_SIZE) ? 0 : i + 1), sine_entry(i)};
    end
    return rom;
  endfunction

  localparam rom_arr_t SINE_ROM = build_rom();

  // e0 + round((e1 - e0) * f / 2^ANGLE_WIDTH), rounding toward plus infinity at the half.
  function automatic logic signed [SAMPLE_WIDTH-1:0] interp(
    input rom_word_t w,
    input logic [ANGLE_WIDTH-1:0] f
  );
    logic signed [SAMPLE_WIDTH-1:0] e0;
    logic signed [SAMPLE_WIDTH-1:0] e1;
    logic signed [D_W-1:0]          d;
    logic signed [T_W-1:0]          t;
    logic signed [V_W-1:0]          q;
    logic signed [V_W-1:0]          v;
    e0 = w[SAMPLE_WIDTH-1:0];
    e1 = w[WORD_W-1:SAMPLE_WIDTH];
    d  = D_W'(e1) - D_W'(e0);
    t  = T_W'(d) * T_W'($signed({1'b0, f})) + (T_W'(1) <<< (ANGLE_WIDTH - 1));
    q  = t[T_W-1:ANGLE_WIDTH];
    v  = V_W'(e0) + q;
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  logic [ANGLE_WIDTH-1:0] angle_c;
  logic [P_W-1:0]         p_s;
  logic [P_W-1:0]         p_c;

  logic [IDX_W-1:0]       idx_s_r;
  logic [IDX_W-1:0]       idx_c_r;
  logic [ANGLE_WIDTH-1:0] frac_s1_r;
  logic [ANGLE_WIDTH-1:0] frac_c1_r;
  rom_word_t              word_s_r;
  rom_word_t              word_c_r;
  logic [ANGLE_WIDTH-1:0] frac_s2_r;
  logic [ANGLE_WIDTH-1:0] frac_c2_r;
  logic signed [SAMPLE_WIDTH-1:0] sin_r;
  logic signed [SAMPLE_WIDTH-1:0] cos_r;

  // Cosine is the sine a quarter turn ahead; the add wraps modulo one turn.
  assign angle_c = angle + ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 2));
  assign p_s     = P_W'(angle) * P_W'(TABLE_SIZE);
  assign p_c     = P_W'(angle_c) * P_W'(TABLE_SIZE);

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_s_r   <= p_s[P_W-1:ANGLE_WIDTH];
      idx_c_r   <= p_c[P_W-1:ANGLE_WIDTH];
      frac_s1_r <= p_s[ANGLE_WIDTH-1:0];
      frac_c1_r <= p_c[ANGLE_WIDTH-1:0];
      word_s_r  <= SINE_ROM[idx_s_r];
      word_c_r  <= SINE_ROM[idx_c_r];
      frac_s2_r <= frac_s1_r;
      frac_c2_r <= frac_c1_r;
      sin_r     <= interp(word_s_r, frac_s2_r);
      cos_r     <= interp(word_c_r, frac_c2_r);
    end
  end

  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule

`default_nettype wire
